[hw/rtl/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define VWBV_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("vwbv assertion failed");

// same, on the usual clk_i / rst_ni pair
`define VWBV_ASSERT(label, prop) \
  `VWBV_ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

[hw/rtl/vwbv_pkg.sv]
// package for the variable-width bit vector core: item types, codes, widths
// no dependencies
`timescale 1ns / 1ps

package vwbv_pkg;

  localparam int WORD_BITS     = 32;
  localparam int MAX_WORDS_DEF = 8;
  localparam int CNT_W         = 6;
  localparam int POS_W         = 9;
  localparam int BIT_OFF_W     = $clog2(WORD_BITS);

  typedef enum logic [1:0] {
    KIND_APPEND  = 2'd0,
    KIND_EXTRACT = 2'd1,
    KIND_REWIND  = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NONE     = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    kind_e                kind;
    logic [WORD_BITS-1:0] field_value;
    logic [CNT_W-1:0]     field_bits;
  } item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] read_value;
    status_e              status;
    logic [POS_W-1:0]     cursor_now;
    logic [POS_W-1:0]     length_now;
  } result_t;

  // accepted item as it leaves the decode stage
  typedef struct packed {
    logic                 vld;
    logic                 do_append;
    logic                 do_extract;
    logic                 word_odd;
    logic                 hi_ok;
    logic                 lo_ok;
    logic [BIT_OFF_W-1:0] bit_off;
    logic [CNT_W-1:0]     nbits;
    logic [WORD_BITS-1:0] value;
    status_e              status;
    logic [POS_W-1:0]     cursor_now;
    logic [POS_W-1:0]     length_now;
  } stage_t;

  function automatic int idx_width(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

[hw/rtl/variable_width_bit_vector_core.sv]
// Variable-width bit vector core. A vector of MAX_WORDS 32-bit words holds bits
// packed MSB-first (bit 0 is the top bit of word 0), with one cursor shared by
// append and extract. An item is accepted on every clock edge where start is
// high; busy stays low, so an item may follow in every cycle. Each item gives
// exactly one result on result_o, shown for one cycle with result_valid_o
// once the item has passed the decode stage register and the result register.
// The receiver cannot stall: the result must be taken in that cycle. Words
// live in an even and an odd bank with registered reads, so both words a
// field may span are read on acceptance and written back at the next edge,
// with a write-through bypass for the item that follows. Clear takes a single
// item; per-word valid bits make every word read as zero until written again.
// Depends on vwbv_pkg, vwbv_ctrl, vwbv_bank and vwbv_merge.
`timescale 1ns / 1ps

module variable_width_bit_vector_core #(
  parameter int MAX_WORDS = vwbv_pkg::MAX_WORDS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  vwbv_pkg::item_t   item_i,
  output logic              busy,
  output logic              result_valid_o,
  output vwbv_pkg::result_t result_o
);
  import vwbv_pkg::*;

  // even bank keeps words 0, 2, 4 ..., odd bank words 1, 3, 5 ...
  localparam int DEPTH_E = (MAX_WORDS + 1) / 2;
  localparam int DEPTH_O = (MAX_WORDS > 1) ? (MAX_WORDS / 2) : 1;
  localparam int AW_E    = idx_width(DEPTH_E);
  localparam int AW_O    = idx_width(DEPTH_O);

  logic                 accept;
  logic                 rd_en;
  logic [AW_E-1:0]      rd_idx_e;
  logic [AW_O-1:0]      rd_idx_o;
  logic                 clr;
  stage_t               stage;
  logic [WORD_BITS-1:0] rd_e, rd_o;
  logic                 we_e, we_o;
  logic [WORD_BITS-1:0] wd_e, wd_o;

  // nothing ever holds the requester off
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // decode: cursor, high-water length and status are settled on acceptance
  vwbv_ctrl #(
    .MAX_WORDS (MAX_WORDS),
    .AW_E      (AW_E),
    .AW_O      (AW_O)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item_i),
    .rd_en_o    (rd_en),
    .rd_idx_e_o (rd_idx_e),
    .rd_idx_o_o (rd_idx_o),
    .clr_o      (clr),
    .stage_o    (stage)
  );

  // word store, split so a spanning field touches one word per bank
  vwbv_bank #(
    .DEPTH (DEPTH_E),
    .AW    (AW_E)
  ) u_bank_e (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (clr),
    .rd_en_i   (rd_en),
    .rd_idx_i  (rd_idx_e),
    .wr_en_i   (we_e),
    .wr_data_i (wd_e),
    .rd_data_o (rd_e)
  );

  vwbv_bank #(
    .DEPTH (DEPTH_O),
    .AW    (AW_O)
  ) u_bank_o (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (clr),
    .rd_en_i   (rd_en),
    .rd_idx_i  (rd_idx_o),
    .wr_en_i   (we_o),
    .wr_data_i (wd_o),
    .rd_data_o (rd_o)
  );

  // extract shift, append merge and write-back, then the result register
  vwbv_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .stage_i        (stage),
    .rd_e_i         (rd_e),
    .rd_o_i         (rd_o),
    .we_e_o         (we_e),
    .wd_e_o         (wd_e),
    .we_o_o         (we_o),
    .wd_o_o         (wd_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

[hw/rtl/vwbv_bank.sv]
// one bank of vector words: registered read, write-back at the last read index,
// write-through bypass and per-word valid bits; uses vwbv_pkg
`timescale 1ns / 1ps

module vwbv_bank #(
  parameter int DEPTH = 4,
  parameter int AW    = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           clr_i,
  input  logic                           rd_en_i,
  input  logic [AW-1:0]                  rd_idx_i,
  input  logic                           wr_en_i,
  input  logic [vwbv_pkg::WORD_BITS-1:0] wr_data_i,
  output logic [vwbv_pkg::WORD_BITS-1:0] rd_data_o
);
  import vwbv_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]     valid_q;
  logic [AW-1:0]        idx_q;
  logic [WORD_BITS-1:0] rd_q;
  logic                 rd_in_range;
  logic                 wr_in_range;
  logic                 bypass;

  assign rd_in_range = {1'b0, rd_idx_i} < (AW+1)'(DEPTH);
  assign wr_in_range = {1'b0, idx_q} < (AW+1)'(DEPTH);
  assign bypass      = wr_en_i && (idx_q == rd_idx_i);

  // write-back goes to the index read for the item now in the merge stage
  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_in_range) begin
      mem[idx_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (bypass) begin
        rd_q <= wr_data_i;
      end else if (rd_in_range && valid_q[rd_idx_i]) begin
        rd_q <= mem[rd_idx_i];
      end else begin
        rd_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      idx_q   <= '0;
    end else begin
      if (rd_en_i) begin
        idx_q <= rd_idx_i;
      end
      // clear wins over a write-back of an older item
      if (clr_i) begin
        valid_q <= '0;
      end else if (wr_en_i && wr_in_range) begin
        valid_q[idx_q] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

[hw/rtl/vwbv_ctrl.sv]
// decode stage: cursor and high-water registers, status, bank read indices
// uses vwbv_pkg
`timescale 1ns / 1ps

module vwbv_ctrl #(
  parameter int MAX_WORDS = vwbv_pkg::MAX_WORDS_DEF,
  parameter int AW_E      = 1,
  parameter int AW_O      = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  vwbv_pkg::item_t  item_i,
  output logic             rd_en_o,
  output logic [AW_E-1:0]  rd_idx_e_o,
  output logic [AW_O-1:0]  rd_idx_o_o,
  output logic             clr_o,
  output vwbv_pkg::stage_t stage_o
);
  import vwbv_pkg::*;

  localparam int CAP = MAX_WORDS * WORD_BITS;
  localparam int CW  = $clog2(CAP + 1);
  localparam int WW  = CW - BIT_OFF_W;

  logic [CW-1:0]    cursor_q, cursor_d;
  logic [CW-1:0]    hw_q, hw_d;
  logic [CNT_W-1:0] n;
  logic [CW:0]      nxt;
  logic [WW-1:0]    word;
  logic [WW:0]      eidx_full;
  logic [WW:0]      oidx_full;
  stage_t           stage_d, stage_q;

  always_comb begin
    n = (item_i.field_bits > CNT_W'(WORD_BITS)) ? CNT_W'(WORD_BITS) : item_i.field_bits;
    nxt  = {1'b0, cursor_q} + (CW+1)'(n);
    word = cursor_q[CW-1:BIT_OFF_W];
    // even bank holds the even one of the pair (word, word+1)
    eidx_full = ({1'b0, word} + (WW+1)'(1)) >> 1;
    oidx_full = {1'b0, word} >> 1;

    cursor_d = cursor_q;
    hw_d     = hw_q;

    stage_d            = '0;
    stage_d.vld        = accept_i;
    stage_d.status     = ST_OK;
    stage_d.word_odd   = word[0];
    stage_d.hi_ok      = {1'b0, word} < (WW+1)'(MAX_WORDS);
    stage_d.lo_ok      = ({1'b0, word} + (WW+1)'(1)) < (WW+1)'(MAX_WORDS);
    stage_d.bit_off    = cursor_q[BIT_OFF_W-1:0];
    stage_d.nbits      = n;
    stage_d.value      = item_i.field_value;

    unique case (item_i.kind)
      KIND_APPEND: begin
        if (n != '0) begin
          if (nxt > (CW+1)'(CAP)) begin
            stage_d.status = ST_OVERFLOW;
          end else begin
            stage_d.do_append = 1'b1;
            cursor_d          = nxt[CW-1:0];
            if (nxt[CW-1:0] > hw_q) begin
              hw_d = nxt[CW-1:0];
            end
          end
        end
      end
      KIND_EXTRACT: begin
        if (nxt > {1'b0, hw_q}) begin
          stage_d.status = ST_NONE;
        end else if (n != '0) begin
          stage_d.do_extract = 1'b1;
          cursor_d           = nxt[CW-1:0];
        end
      end
      KIND_REWIND: begin
        cursor_d = '0;
      end
      KIND_CLEAR: begin
        cursor_d = '0;
        hw_d     = '0;
      end
      default: begin
      end
    endcase

    stage_d.cursor_now = POS_W'(cursor_d);
    stage_d.length_now = POS_W'(hw_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      hw_q     <= '0;
      stage_q  <= '0;
    end else begin
      stage_q <= stage_d;
      if (accept_i) begin
        cursor_q <= cursor_d;
        hw_q     <= hw_d;
      end
    end
  end

  assign rd_en_o    = accept_i;
  assign rd_idx_e_o = AW_E'(eidx_full);
  assign rd_idx_o_o = AW_O'(oidx_full);
  assign clr_o      = accept_i && (item_i.kind == KIND_CLEAR);
  assign stage_o    = stage_q;

endmodule

[hw/rtl/vwbv_merge.sv]
// merge stage: window shift for extract, field placement and OR for append,
// bank write-back and the result register; uses vwbv_pkg
`timescale 1ns / 1ps

module vwbv_merge (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  vwbv_pkg::stage_t               stage_i,
  input  logic [vwbv_pkg::WORD_BITS-1:0] rd_e_i,
  input  logic [vwbv_pkg::WORD_BITS-1:0] rd_o_i,
  output logic                           we_e_o,
  output logic [vwbv_pkg::WORD_BITS-1:0] wd_e_o,
  output logic                           we_o_o,
  output logic [vwbv_pkg::WORD_BITS-1:0] wd_o_o,
  output logic                           result_valid_o,
  output vwbv_pkg::result_t              result_o
);
  import vwbv_pkg::*;

  localparam int WIN_BITS = 2 * WORD_BITS;
  localparam int SH_W     = $clog2(WIN_BITS + 1);

  logic [WORD_BITS-1:0] hi_w, lo_w;
  logic [WORD_BITS:0]   mask_w;
  logic [WORD_BITS-1:0] fmask;
  logic [SH_W-1:0]      sh;
  logic [WIN_BITS-1:0]  shifted;
  logic [WIN_BITS-1:0]  placed;
  logic [WORD_BITS-1:0] rdval;
  logic [WORD_BITS-1:0] new_hi, new_lo;
  logic                 valid_q;
  result_t              res_d, res_q;

  always_comb begin
    hi_w = stage_i.word_odd ? rd_o_i : rd_e_i;
    lo_w = stage_i.word_odd ? rd_e_i : rd_o_i;
    if (!stage_i.hi_ok) begin
      hi_w = '0;
    end
    if (!stage_i.lo_ok) begin
      lo_w = '0;
    end

    mask_w = ((WORD_BITS+1)'(1) << stage_i.nbits) - (WORD_BITS+1)'(1);
    fmask  = mask_w[WORD_BITS-1:0];
    // field sits MSB-first at bit_off within the two-word window
    sh = SH_W'(WIN_BITS) - SH_W'(stage_i.bit_off) - SH_W'(stage_i.nbits);

    shifted = {hi_w, lo_w} >> sh;
    rdval   = stage_i.do_extract ? (shifted[WORD_BITS-1:0] & fmask) : '0;

    placed = {{WORD_BITS{1'b0}}, stage_i.value & fmask} << sh;
    new_hi = hi_w | placed[WIN_BITS-1:WORD_BITS];
    new_lo = lo_w | placed[WORD_BITS-1:0];

    we_e_o = stage_i.vld && stage_i.do_append &&
             (stage_i.word_odd ? stage_i.lo_ok : stage_i.hi_ok);
    we_o_o = stage_i.vld && stage_i.do_append &&
             (stage_i.word_odd ? stage_i.hi_ok : stage_i.lo_ok);
    wd_e_o = stage_i.word_odd ? new_lo : new_hi;
    wd_o_o = stage_i.word_odd ? new_hi : new_lo;

    res_d.read_value = rdval;
    res_d.status     = stage_i.status;
    res_d.cursor_now = stage_i.cursor_now;
    res_d.length_now = stage_i.length_now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule

[hw/rtl/vwbv_checker.sv]
// port-level checker for the bit vector core, bound to the top level
// uses vwbv_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vwbv_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input vwbv_pkg::item_t   item_i,
  input logic              busy,
  input logic              result_valid_o,
  input vwbv_pkg::result_t result_o
);
  import vwbv_pkg::*;

  logic acc;
  assign acc = start && !busy;

  // exactly one result for each accepted item, and none without one
  `VWBV_ASSERT(a_one_result, $past(rst_ni) && $past(rst_ni, 2) |-> (result_valid_o == $past(acc, 2)))

  // a dropped append leaves cursor and length as the previous item left them
  `VWBV_ASSERT(a_overflow_keeps, $past(rst_ni) && result_valid_o && $past(result_valid_o) && (result_o.status == ST_OVERFLOW) |-> (result_o.cursor_now == $past(result_o.cursor_now)) && (result_o.length_now == $past(result_o.length_now)))

  // a failed extract reads nothing and moves nothing
  `VWBV_ASSERT(a_none_keeps, $past(rst_ni) && result_valid_o && $past(result_valid_o) && (result_o.status == ST_NONE) |-> (result_o.read_value == '0) && (result_o.cursor_now == $past(result_o.cursor_now)))

  // rewind always succeeds and lands the cursor at zero
  `VWBV_ASSERT(a_rewind_zero, $past(rst_ni) && $past(rst_ni, 2) && $past(acc && (item_i.kind == KIND_REWIND), 2) |-> (result_o.cursor_now == '0) && (result_o.status == ST_OK))

endmodule

bind variable_width_bit_vector_core vwbv_checker u_checker (.*);

[dv/variable_width_bit_vector_core_tb.sv]
// self-checking bench for variable_width_bit_vector_core: directed and random items
// mirrors the bit vector, cursor and length in its own predictor; depends on vwbv_pkg
`timescale 1ns / 1ps

module variable_width_bit_vector_core_tb;
  import vwbv_pkg::*;

  localparam int VEC_WORDS = MAX_WORDS_DEF;
  localparam int VEC_BITS  = VEC_WORDS * WORD_BITS;
  localparam int RAND_ITEMS = 820;
  // hard ceiling with a wide margin over the worst-case run
  localparam int CYCLE_LIMIT = 200000;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  item_t   item_i = '0;
  logic    busy;
  logic    result_valid_o;
  result_t result_o;

  // predicted copy of the vector state
  logic [WORD_BITS-1:0] vec_words [VEC_WORDS];
  int unsigned          vec_cursor;
  int unsigned          vec_length;

  result_t pending_results [$];
  int      error_count = 0;
  int      cycles = 0;
  int      items_sent = 0;
  bit      no_idle = 1'b0;

  variable_width_bit_vector_core #(
    .MAX_WORDS(VEC_WORDS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .item_i        (item_i),
    .busy          (busy),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  // 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // hard stop in case results never arrive
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void clear_vector();
    for (int i = 0; i < VEC_WORDS; i++) vec_words[i] = '0;
    vec_cursor = 0;
    vec_length = 0;
  endfunction

  // applies one item to the predicted state and returns the result it gives
  function automatic result_t apply_to_vector(item_t it);
    result_t     r;
    int unsigned n;
    int unsigned word;
    int unsigned bitpos;
    logic [63:0] mask;
    logic [63:0] placed;
    logic [63:0] window;
    r = '0;
    r.status = ST_OK;
    // counts above a word saturate to a full word
    n = (it.field_bits > WORD_BITS) ? WORD_BITS : it.field_bits;
    mask = (64'd1 << n) - 64'd1;
    word = vec_cursor / WORD_BITS;
    bitpos = vec_cursor % WORD_BITS;
    case (it.kind)
      KIND_APPEND: begin
        if (n != 0) begin
          if (vec_cursor + n > VEC_BITS) begin
            r.status = ST_OVERFLOW;
          end else begin
            // field lands MSB-first at the cursor, possibly across two words
            placed = ({32'd0, it.field_value} & mask) << (64 - bitpos - n);
            if (word < VEC_WORDS) vec_words[word] |= placed[63:32];
            if (word + 1 < VEC_WORDS) vec_words[word+1] |= placed[31:0];
            vec_cursor = vec_cursor + n;
            if (vec_cursor > vec_length) vec_length = vec_cursor;
          end
        end
      end
      KIND_EXTRACT: begin
        if (vec_cursor + n > vec_length) begin
          r.status = ST_NONE;
        end else if (n != 0) begin
          window[63:32] = (word < VEC_WORDS) ? vec_words[word] : '0;
          window[31:0]  = (word + 1 < VEC_WORDS) ? vec_words[word+1] : '0;
          r.read_value = 32'((window >> (64 - bitpos - n)) & mask);
          vec_cursor = vec_cursor + n;
        end
      end
      KIND_REWIND: begin
        vec_cursor = 0;
      end
      default: begin
        clear_vector();
      end
    endcase
    r.cursor_now = vec_cursor[POS_W-1:0];
    r.length_now = vec_length[POS_W-1:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // one process watches both sides: accepted items are predicted at the edge
  // that takes them, results are checked at the edge that ends their cycle;
  // values read here are the ones settled before the edge
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result with no item outstanding, expected none, actual %h",
                 $time, result_o);
      end else begin
        want = pending_results.pop_front();
        check_field("read_value", want.read_value, result_o.read_value);
        check_field("status", 32'(want.status), 32'(result_o.status));
        check_field("cursor_now", 32'(want.cursor_now), 32'(result_o.cursor_now));
        check_field("length_now", 32'(want.length_now), 32'(result_o.length_now));
      end
    end
    if (rst_ni && start && !busy) pending_results.push_back(apply_to_vector(item_i));
  end

  function automatic item_t mk_item(kind_e k, logic [31:0] v, logic [5:0] n);
    item_t it;
    it.kind = k;
    it.field_value = v;
    it.field_bits = n;
    return it;
  endfunction

  // sender gap: often none, otherwise a randomly drawn run of idle cycles
  function automatic int pick_gap();
    if (no_idle || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 18);
  endfunction

  // mostly in-range counts, with some zero and some saturating ones
  function automatic logic [5:0] pick_bits();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 6'd0;
    if (r == 1) return 6'($urandom_range(33, 63));
    return 6'($urandom_range(1, 32));
  endfunction

  // drive one item and hold it until the block takes it
  task automatic send_item(item_t it);
    int gap;
    bit taken;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
    items_sent++;
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // empty vector, zero-length items and extract past the end
  task automatic test_empty_and_zero();
    send_item(mk_item(KIND_CLEAR, 32'hFFFF_FFFF, 6'd63));
    send_item(mk_item(KIND_EXTRACT, 32'h0, 6'd5));
    send_item(mk_item(KIND_EXTRACT, 32'h0, 6'd0));
    send_item(mk_item(KIND_APPEND, 32'hFFFF_FFFF, 6'd0));
    send_item(mk_item(KIND_REWIND, 32'h1234_5678, 6'd17));
  endtask

  // fields across word edges, excess value bits, saturated counts, or-in after rewind
  task automatic test_span_and_saturate();
    send_item(mk_item(KIND_APPEND, 32'hFFFF_FFE5, 6'd5));
    send_item(mk_item(KIND_APPEND, 32'hA5A5_A5A5, 6'd32));
    send_item(mk_item(KIND_APPEND, 32'h1234_5678, 6'd63));
    send_item(mk_item(KIND_APPEND, 32'h0000_0001, 6'd1));
    send_item(mk_item(KIND_REWIND, 32'h0, 6'd0));
    send_item(mk_item(KIND_EXTRACT, 32'h0, 6'd63));
    send_item(mk_item(KIND_EXTRACT, 32'h0, 6'd1));
    send_item(mk_item(KIND_EXTRACT, 32'h0, 6'd0));
    send_item(mk_item(KIND_EXTRACT, 32'h0, 6'd32));
    send_item(mk_item(KIND_EXTRACT, 32'h0, 6'd1));
    send_item(mk_item(KIND_REWIND, 32'h0, 6'd0));
    send_item(mk_item(KIND_APPEND, 32'h0000_0055, 6'd7));
    send_item(mk_item(KIND_REWIND, 32'h0, 6'd0));
    send_item(mk_item(KIND_EXTRACT, 32'h0, 6'd40));
  endtask

  // fill to the last bit, then one more; then try to extract past the end
  task automatic test_capacity();
    send_item(mk_item(KIND_CLEAR, 32'h0, 6'd0));
    for (int i = 0; i < VEC_WORDS; i++)
      send_item(mk_item(KIND_APPEND, (i % 2) ? 32'hC3C3_3C3C : 32'hFFFF_FFFF, 6'd32));
    send_item(mk_item(KIND_APPEND, 32'h1, 6'd1));
    send_item(mk_item(KIND_EXTRACT, 32'h0, 6'd0));
    send_item(mk_item(KIND_EXTRACT, 32'h0, 6'd1));
    send_item(mk_item(KIND_REWIND, 32'h0, 6'd0));
  endtask

  // packet-like runs: an optional clear, appends, a rewind, then extracts; plus random noise items
  task automatic test_random(int count);
    int target;
    int k;
    int k2;
    target = items_sent + count;
    while (items_sent < target) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 70) begin
        if ($urandom_range(0, 3) == 0) send_item(mk_item(KIND_CLEAR, $urandom, pick_bits()));
        k = $urandom_range(1, 10);
        for (int i = 0; i < k; i++) send_item(mk_item(KIND_APPEND, $urandom, pick_bits()));
        send_item(mk_item(KIND_REWIND, $urandom, pick_bits()));
        k2 = $urandom_range(1, k + 2);
        for (int i = 0; i < k2; i++) send_item(mk_item(KIND_EXTRACT, $urandom, pick_bits()));
      end else begin
        send_item(mk_item(kind_e'($urandom_range(0, 3)), $urandom,
                          6'($urandom_range(0, 63))));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    clear_vector();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_zero();
    test_span_and_saturate();
    test_capacity();
    test_random(RAND_ITEMS / 2);
    // sender holds off until the block has nothing outstanding
    wait_drained();
    test_random(RAND_ITEMS - RAND_ITEMS / 2);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
